FILE: hdl/plps_pkg.sv
`timescale 1ns / 1ps

package plps_pkg;

  localparam int COORD_BITS = 24;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int RAD_BITS   = SQ_BITS + 2;
  localparam int ROOT_BITS  = RAD_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int TOTAL_BITS = 40;
  localparam int SEG_BITS   = 26;
  localparam int SQRT_STEPS = RAD_BITS / 2;
  localparam int CNT_BITS   = $clog2(SQRT_STEPS);
  localparam int PC_BITS    = 3;

  localparam int IN_DATA_BITS  = 96;
  localparam int OUT_DATA_BITS = 96;

  // microprogram addresses
  localparam logic [PC_BITS-1:0] ST_WAIT  = 3'd0;
  localparam logic [PC_BITS-1:0] ST_MUL_X = 3'd1;
  localparam logic [PC_BITS-1:0] ST_MUL_Y = 3'd2;
  localparam logic [PC_BITS-1:0] ST_MUL_Z = 3'd3;
  localparam logic [PC_BITS-1:0] ST_INIT  = 3'd4;
  localparam logic [PC_BITS-1:0] ST_ROOT  = 3'd5;
  localparam logic [PC_BITS-1:0] ST_DONE  = 3'd6;
  localparam logic [PC_BITS-1:0] ST_FIRST = 3'd7;

  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_Z
  } sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT,    // advance
    JMP_ACCEPT,  // hold until a request arrives, branch on trajectory start
    JMP_LOOP,    // repeat until the iteration count runs out
    JMP_OUT      // hold until the result register is free, then jump to target
  } jmp_t;

  typedef struct packed {
    logic               in_rdy;
    sel_t               sel;
    logic               mul_en;
    logic               acc_clr;
    logic               acc_add;
    logic               sq_init;
    logic               sq_step;
    logic               fin_seg;
    logic               fin_first;
    jmp_t               jmp;
    logic [PC_BITS-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ctrl_t c;
    c = '{in_rdy: 1'b0, sel: SEL_X, mul_en: 1'b0, acc_clr: 1'b0, acc_add: 1'b0,
          sq_init: 1'b0, sq_step: 1'b0, fin_seg: 1'b0, fin_first: 1'b0,
          jmp: JMP_NEXT, target: ST_WAIT};
    case (pc)
      ST_WAIT: begin
        c.in_rdy = 1'b1;
        c.jmp    = JMP_ACCEPT;
        c.target = ST_FIRST;
      end
      ST_MUL_X: begin
        c.sel     = SEL_X;
        c.mul_en  = 1'b1;
        c.acc_clr = 1'b1;
      end
      ST_MUL_Y: begin
        c.sel     = SEL_Y;
        c.mul_en  = 1'b1;
        c.acc_add = 1'b1;
      end
      ST_MUL_Z: begin
        c.sel     = SEL_Z;
        c.mul_en  = 1'b1;
        c.acc_add = 1'b1;
      end
      ST_INIT: begin
        c.sq_init = 1'b1;
      end
      ST_ROOT: begin
        c.sq_step = 1'b1;
        c.jmp     = JMP_LOOP;
      end
      ST_DONE: begin
        c.fin_seg = 1'b1;
        c.jmp     = JMP_OUT;
        c.target  = ST_WAIT;
      end
      ST_FIRST: begin
        c.fin_first = 1'b1;
        c.jmp       = JMP_OUT;
        c.target    = ST_WAIT;
      end
      default: begin
        c.jmp    = JMP_OUT;
        c.target = ST_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/path_length_and_peak_speed.sv
`timescale 1ns / 1ps

// Channel | Direction | tdata (low bit up)                         | tuser
// in_     | sink      | pos_x, pos_y, pos_z, point_speed           | start_new
// out_    | source    | path_total, segment_length, peak_speed, 0s | total_saturated
//
// A first point of a trajectory goes from the accepting step to its own finishing step;
// any other point passes three squaring steps on one 24x24 multiplier, one load step, 25
// steps of a bit-pair square root and one finishing step, all sequenced by a ROM. One
// point is in work at a time, and the next request is taken while the result waits.
// rst_n is synchronous, active low; a stalled result holds the sequencer in its
// finishing step.

module path_length_and_peak_speed
  import plps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // pos_x, pos_y, pos_z, point_speed
  input  logic                     in_tuser,   // start_new
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // path_total, segment_length, peak_speed
  output logic                     out_tuser   // total_saturated
);

  logic [PC_BITS-1:0] pc_r, pc_nxt;
  ctrl_t              ctl;

  logic signed [COORD_BITS-1:0] x_r, y_r, z_r, spd_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic                         have_prev_r;

  logic [SQ_BITS-1:0]   prod_r;
  logic [RAD_BITS-1:0]  acc_r;
  logic [RAD_BITS-1:0]  rad_r;
  logic [REM_BITS-1:0]  rem_r;
  logic [ROOT_BITS-1:0] root_r;
  logic [CNT_BITS-1:0]  cnt_r;

  logic [TOTAL_BITS-1:0]        total_r;
  logic signed [COORD_BITS-1:0] peak_r;
  logic                         sat_r;

  logic                         out_valid_r;
  logic [TOTAL_BITS-1:0]        out_total_r;
  logic [SEG_BITS-1:0]          out_seg_r;
  logic signed [COORD_BITS-1:0] out_peak_r;
  logic                         out_sat_r;

  logic                         in_acc;
  logic                         out_free;
  logic                         first_pt;
  logic signed [COORD_BITS-1:0] op_a, op_b;
  logic signed [COORD_BITS:0]   diff;
  logic [MAG_BITS-1:0]          mag;
  logic [REM_BITS+1:0]          rem_t;
  logic [REM_BITS+1:0]          trial;
  logic                         take;
  logic [TOTAL_BITS:0]          sum;
  logic [TOTAL_BITS-1:0]        total_new;
  logic                         sat_new;
  logic signed [COORD_BITS-1:0] peak_new;

  assign ctl       = ucode_rom(pc_r);
  // hold off requests in reset
  assign in_tready = ctl.in_rdy && rst_n;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign first_pt  = in_tuser || !have_prev_r;

  always_comb begin
    pc_nxt = pc_r;
    case (ctl.jmp)
      JMP_NEXT:   pc_nxt = pc_r + 1'b1;
      JMP_ACCEPT: if (in_acc) begin
        pc_nxt = first_pt ? ctl.target : pc_r + 1'b1;
      end
      JMP_LOOP:   if (cnt_r == '0) begin
        pc_nxt = pc_r + 1'b1;
      end
      JMP_OUT:    if (out_free) begin
        pc_nxt = ctl.target;
      end
      default:    pc_nxt = ST_WAIT;
    endcase
  end

  // operand select and absolute difference feeding the multiplier
  always_comb begin
    case (ctl.sel)
      SEL_X: begin
        op_a = x_r;
        op_b = prev_x_r;
      end
      SEL_Y: begin
        op_a = y_r;
        op_b = prev_y_r;
      end
      SEL_Z: begin
        op_a = z_r;
        op_b = prev_z_r;
      end
      default: begin
        op_a = x_r;
        op_b = prev_x_r;
      end
    endcase
    diff = {op_a[COORD_BITS-1], op_a} - {op_b[COORD_BITS-1], op_b};
    mag  = diff[COORD_BITS] ? MAG_BITS'(-diff) : diff[MAG_BITS-1:0];
  end

  // one bit-pair of the restoring square root
  always_comb begin
    rem_t = {rem_r, rad_r[RAD_BITS-1 -: 2]};
    trial = {2'b00, root_r, 2'b01};
    take  = rem_t >= trial;
  end

  always_comb begin
    sum       = {1'b0, total_r} + (TOTAL_BITS + 1)'(root_r);
    total_new = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
    sat_new   = sat_r || sum[TOTAL_BITS];
    peak_new  = (spd_r > peak_r) ? spd_r : peak_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_WAIT;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      peak_r      <= '0;
      sat_r       <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
    end else begin
      pc_r <= pc_nxt;
      if ((ctl.fin_seg || ctl.fin_first) && out_free) begin
        out_valid_r <= 1'b1;
        have_prev_r <= 1'b1;
        prev_x_r    <= x_r;
        prev_y_r    <= y_r;
        prev_z_r    <= z_r;
        if (ctl.fin_first) begin
          total_r <= '0;
          sat_r   <= 1'b0;
          peak_r  <= spd_r;
        end else begin
          total_r <= total_new;
          sat_r   <= sat_new;
          peak_r  <= peak_new;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r     <= in_tdata[COORD_BITS-1:0];
      y_r     <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      z_r     <= in_tdata[3*COORD_BITS-1:2*COORD_BITS];
      spd_r   <= in_tdata[4*COORD_BITS-1:3*COORD_BITS];
    end
    if (ctl.mul_en) begin
      prod_r <= mag * mag;
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + RAD_BITS'(prod_r);
    end
    if (ctl.sq_init) begin
      rad_r  <= acc_r + RAD_BITS'(prod_r);
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNT_BITS'(SQRT_STEPS - 1);
    end else if (ctl.sq_step) begin
      rad_r <= rad_r << 2;
      cnt_r <= cnt_r - 1'b1;
      if (take) begin
        rem_r  <= REM_BITS'(rem_t - trial);
        root_r <= {root_r[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= REM_BITS'(rem_t);
        root_r <= {root_r[ROOT_BITS-2:0], 1'b0};
      end
    end
    if ((ctl.fin_seg || ctl.fin_first) && out_free) begin
      if (ctl.fin_first) begin
        out_total_r <= '0;
        out_seg_r   <= '0;
        out_peak_r  <= spd_r;
        out_sat_r   <= 1'b0;
      end else begin
        out_total_r <= total_new;
        out_seg_r   <= SEG_BITS'(root_r);
        out_peak_r  <= peak_new;
        out_sat_r   <= sat_new;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_BITS - TOTAL_BITS - SEG_BITS - COORD_BITS){1'b0}},
                       out_peak_r, out_seg_r, out_total_r};
  assign out_tuser  = out_sat_r;

endmodule
